FILE: hw/rtl/ott_pkg.sv
// shared types and constants for the one-shot timer table
// no dependencies
`timescale 1ns / 1ps

package ott_pkg;

  // sizes
  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_REPORTS   = 16;
  localparam int CMD_W         = 2;
  localparam int ID_W          = 16;
  localparam int TIME_W        = 32;
  localparam int STATUS_W      = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_DEREGISTER = 2'd1,
    CMD_CLEAR      = 2'd2,
    CMD_TICK       = 2'd3
  } cmd_t;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic clear;
    logic rd_en;
    logic finish;
  } ott_ctl_t;

endpackage

FILE: hw/rtl/ott_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module ott_ram #(
  parameter int WIDTH  = 48,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/ott_ctrl.sv
// controller state machine: accepts commands and sweeps the slot index
// depends on ott_pkg
`timescale 1ns / 1ps

module ott_ctrl #(
  parameter int NUM_SLOTS = ott_pkg::NUM_SLOTS_DEF,
  parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ott_pkg::CMD_W-1:0]  command,
  output logic                       busy,
  output ott_pkg::ott_ctl_t          ctl,
  output logic [IDX_W-1:0]           rd_idx
);
  import ott_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;

  // state and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          if (command == CMD_CLEAR) begin
            ctl.clear = 1'b1;
          end else begin
            state_next = S_SCAN;
            cnt_next   = '0;
          end
        end
      end
      S_SCAN: begin
        ctl.rd_en = 1'b1;
        if (cnt == LAST_IDX) begin
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign rd_idx = cnt;

endmodule

FILE: hw/rtl/ott_dp.sv
// datapath: slot valid bits, slot ram, per-slot update and result registers
// depends on ott_pkg and ott_ram
`timescale 1ns / 1ps

module ott_dp #(
  parameter int NUM_SLOTS = ott_pkg::NUM_SLOTS_DEF,
  parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ott_pkg::ott_ctl_t             ctl,
  input  logic [IDX_W-1:0]              rd_idx,
  input  logic [ott_pkg::CMD_W-1:0]     command,
  input  logic [ott_pkg::ID_W-1:0]      timer_id,
  input  logic [ott_pkg::TIME_W-1:0]    timeout_ms,
  output logic                          result_valid,
  output logic                          result_kind,
  output logic [ott_pkg::STATUS_W-1:0]  status,
  output logic [ott_pkg::ID_W-1:0]      expired_id,
  output logic                          last
);
  import ott_pkg::*;

  localparam int RAM_W = ID_W + TIME_W;
  localparam int RPT_W = $clog2(MAX_REPORTS + 1);
  localparam logic [RPT_W-1:0] RPT_MAX = RPT_W'(MAX_REPORTS);

  // latched command
  cmd_t              cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] timeout_q;

  // slot valid bits
  logic [NUM_SLOTS-1:0] active, active_next;

  // sweep flags
  logic              dup, dup_next;
  logic              found, found_next;
  logic              free_found, free_found_next;
  logic [IDX_W-1:0]  free_idx, free_idx_next;
  logic [RPT_W-1:0]  rpt_cnt, rpt_cnt_next;
  logic              pend_valid, pend_valid_next;
  logic [ID_W-1:0]   pend_id, pend_id_next;

  // processing stage
  logic              proc_valid;
  logic [IDX_W-1:0]  proc_idx;

  // ram ports
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [RAM_W-1:0]  wdata;
  logic [RAM_W-1:0]  rdata;

  // result next values
  logic                res_valid_next;
  logic                res_kind_next;
  logic [STATUS_W-1:0] res_status_next;
  logic [ID_W-1:0]     res_id_next;
  logic                res_last_next;

  // slot fields of the entry under processing
  logic [ID_W-1:0]   slot_id;
  logic [TIME_W-1:0] slot_rem;
  logic [TIME_W-1:0] rem_dec;
  logic              slot_act;

  ott_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_SLOTS),
    .ADDR_W(IDX_W)
  ) u_slot_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ctl.rd_en),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  assign slot_id  = rdata[RAM_W-1:TIME_W];
  assign slot_rem = rdata[TIME_W-1:0];
  assign slot_act = active[proc_idx];
  assign rem_dec  = (slot_rem == '0) ? '0 : slot_rem - 1'b1;

  // per-slot update, final status and expiry reporting
  always_comb begin
    active_next     = active;
    dup_next        = dup;
    found_next      = found;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    rpt_cnt_next    = rpt_cnt;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    we              = 1'b0;
    waddr           = proc_idx;
    wdata           = {slot_id, rem_dec};
    res_valid_next  = 1'b0;
    res_kind_next   = KIND_STATUS;
    res_status_next = ST_OK;
    res_id_next     = '0;
    res_last_next   = 1'b0;

    if (ctl.accept) begin
      dup_next        = 1'b0;
      found_next      = 1'b0;
      free_found_next = 1'b0;
      free_idx_next   = '0;
      rpt_cnt_next    = '0;
      pend_valid_next = 1'b0;
    end

    if (ctl.clear) begin
      active_next     = '0;
      res_valid_next  = 1'b1;
      res_kind_next   = KIND_STATUS;
      res_status_next = ST_OK;
      res_last_next   = 1'b1;
    end

    if (proc_valid) begin
      case (cmd_q)
        CMD_REGISTER: begin
          if (slot_act && slot_id == id_q) begin
            dup_next = 1'b1;
          end
          if (!slot_act && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = proc_idx;
          end
        end
        CMD_DEREGISTER: begin
          if (slot_act && slot_id == id_q && id_q != '0) begin
            found_next            = 1'b1;
            active_next[proc_idx] = 1'b0;
          end
        end
        CMD_TICK: begin
          if (slot_act) begin
            we = 1'b1;
            if (rem_dec == '0 && rpt_cnt != RPT_MAX) begin
              // earlier report goes out now, this one waits for its last flag
              res_valid_next        = pend_valid;
              res_kind_next         = KIND_EXPIRY;
              res_id_next           = pend_id;
              pend_valid_next       = 1'b1;
              pend_id_next          = slot_id;
              rpt_cnt_next          = rpt_cnt + 1'b1;
              active_next[proc_idx] = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (ctl.finish) begin
      case (cmd_q)
        CMD_REGISTER: begin
          res_valid_next = 1'b1;
          res_last_next  = 1'b1;
          if (id_q == '0 || dup) begin
            res_status_next = ST_BAD_ID;
          end else if (free_found) begin
            res_status_next       = ST_OK;
            active_next[free_idx] = 1'b1;
            we                    = 1'b1;
            waddr                 = free_idx;
            wdata                 = {id_q, timeout_q};
          end else begin
            res_status_next = ST_FULL;
          end
        end
        CMD_DEREGISTER: begin
          res_valid_next  = 1'b1;
          res_last_next   = 1'b1;
          res_status_next = found ? ST_OK : ST_BAD_ID;
        end
        CMD_TICK: begin
          res_valid_next  = pend_valid;
          res_kind_next   = KIND_EXPIRY;
          res_id_next     = pend_id;
          res_last_next   = 1'b1;
          pend_valid_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= '0;
      proc_valid   <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      active       <= active_next;
      proc_valid   <= ctl.rd_en;
      pend_valid   <= pend_valid_next;
      result_valid <= res_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q     <= cmd_t'(command);
      id_q      <= timer_id;
      timeout_q <= timeout_ms;
    end
    proc_idx    <= rd_idx;
    dup         <= dup_next;
    found       <= found_next;
    free_found  <= free_found_next;
    free_idx    <= free_idx_next;
    rpt_cnt     <= rpt_cnt_next;
    pend_id     <= pend_id_next;
    result_kind <= res_kind_next;
    status      <= res_status_next;
    expired_id  <= res_id_next;
    last        <= res_last_next;
  end

endmodule

FILE: hw/rtl/one_shot_timer_table_unit.sv
// One-shot timer table. Register/deregister/tick sweep the slot ram once, one slot per
// cycle: busy from the accept through the scan, drain and done states; results end as busy falls.
// Clear is handled in idle; its status shows on the next cycle and busy stays low.
// Tick expiry reports (at most MAX_REPORTS per tick) come out during and at the end of the sweep,
// at most one per cycle; the receiver cannot stall. Commands are accepted only while not busy.
// Synchronous reset empties every slot by clearing the slot valid bits.
`timescale 1ns / 1ps

module one_shot_timer_table_unit #(
  parameter int NUM_SLOTS = ott_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ott_pkg::CMD_W-1:0]     command,
  input  logic [ott_pkg::ID_W-1:0]      timer_id,
  input  logic [ott_pkg::TIME_W-1:0]    timeout_ms,
  output logic                          result_valid,
  output logic                          result_kind,
  output logic [ott_pkg::STATUS_W-1:0]  status,
  output logic [ott_pkg::ID_W-1:0]      expired_id,
  output logic                          last
);
  import ott_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  ott_ctl_t         ctl;
  logic [IDX_W-1:0] rd_idx;

  ott_ctrl #(
    .NUM_SLOTS(NUM_SLOTS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .busy   (busy),
    .ctl    (ctl),
    .rd_idx (rd_idx)
  );

  ott_dp #(
    .NUM_SLOTS(NUM_SLOTS),
    .IDX_W    (IDX_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .rd_idx      (rd_idx),
    .command     (command),
    .timer_id    (timer_id),
    .timeout_ms  (timeout_ms),
    .result_valid(result_valid),
    .result_kind (result_kind),
    .status      (status),
    .expired_id  (expired_id),
    .last        (last)
  );

  // command status results are single and carry no id
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_STATUS |-> last && expired_id == '0)
    else $error("status result without last or with an id");

  // expiry reports always carry success status
  a_expiry_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_EXPIRY |-> status == ST_OK)
    else $error("expiry report with nonzero status");

  // a non-clear transfer starts a sweep
  a_sweep_starts: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command != CMD_CLEAR |=> busy)
    else $error("sweep did not start after transfer");

  // a clear transfer gives its status on the next cycle
  a_clear_status: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == CMD_CLEAR |=> result_valid && result_kind == KIND_STATUS)
    else $error("clear produced no status");

endmodule
